[hw/rtl/bmmf_pkg.sv]
// ---------------------------------------------------------------------------
// bmmf_pkg
// Shared types and constants for the button matrix footswitch scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package bmmf_pkg;

   localparam int PinW       = 10;
   localparam int MaxBpr     = 8;
   localparam int MaxResults = 15;
   localparam int AddrW      = 5;
   localparam int DataW      = 32;

   localparam logic [6:0] NoteBaseRst = 7'h45;
   localparam logic [7:0] StatusARst  = 8'h96;
   localparam logic [7:0] StatusBRst  = 8'h97;
   localparam logic [6:0] VelLowRst   = 7'h01;
   localparam logic [6:0] VelHighRst  = 7'h7F;

   typedef enum logic [2:0] {
      REG_NOTE_BASE = 3'd0,
      REG_STATUS_A  = 3'd1,
      REG_STATUS_B  = 3'd2,
      REG_VEL_LOW   = 3'd3,
      REG_VEL_HIGH  = 3'd4
   } reg_idx_type;

   typedef enum logic [1:0] {
      PH_OPEN = 2'd0,
      PH_DOWN = 2'd1,
      PH_HELD = 2'd2,
      PH_UP   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      SEL_STATUS = 2'd0,
      SEL_NOTE   = 2'd1,
      SEL_VEL    = 2'd2
   } sel_type;

   typedef struct packed {
      logic [6:0] note_base;
      logic [7:0] status_a;
      logic [7:0] status_b;
      logic [6:0] vel_low;
      logic [6:0] vel_high;
   } cfg_type;

   // one scan's worth of releases: mask of releasing lanes, row, status and
   // the velocity value each lane sends
   typedef struct packed {
      logic [MaxBpr-1:0]      mask;
      logic                   row;
      logic [7:0]             status;
      logic [MaxBpr-1:0][6:0] vel;
   } msg_type;

endpackage

`default_nettype wire

[hw/rtl/bmmf_if.sv]
// ---------------------------------------------------------------------------
// bmmf_if
// Valid/ready channels for scan samples and MIDI result bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface bmmf_req_if;
   import bmmf_pkg::*;

   logic            valid;
   logic            ready;
   logic [PinW-1:0] pin_status;

   modport source (output valid, output pin_status, input ready);
   modport sink (input valid, input pin_status, output ready);
endinterface

interface bmmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;
   logic [3:0] button;
   logic       last;

   modport source (output valid, output midi_byte, output button, output last, input ready);
   modport sink (input valid, input midi_byte, input button, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/bmmf_scan.sv]
// ---------------------------------------------------------------------------
// bmmf_scan
// Per-sample debounce state machines, bank and velocity toggle state.
// ---------------------------------------------------------------------------
`default_nettype none

module bmmf_scan #(
   parameter int BPR = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    go,
   input  wire logic [bmmf_pkg::PinW-1:0] pins,
   input  wire bmmf_pkg::cfg_type       cfg,
   output logic                         emit,
   output bmmf_pkg::msg_type            msg
);
   import bmmf_pkg::*;

   logic                drive_row_ff;
   logic                bank_ff;
   logic                bank_in;
   phase_type           phase_ff [2][BPR];
   phase_type           phase_in [BPR];
   logic [BPR-1:0]      vel_bit_ff [2][2];
   logic [BPR-1:0]      pressed;
   logic [BPR-1:0]      release_hit;
   logic [BPR-1:0]      cur_vel;
   logic [2*MaxBpr-1:0] pins_ext;
   logic                hit;
   phase_type           ph;

   always_comb begin
      pins_ext = (2*MaxBpr)'(pins);
      hit      = 1'b0;
      pressed  = '0;
      for (int k = 0; k < BPR; k++) begin
         if (!hit && pins_ext[2*k +: 2] == 2'b00) begin
            hit        = 1'b1;
            pressed[k] = 1'b1;
         end
      end

      for (int k = 0; k < BPR; k++) begin
         ph = phase_ff[drive_row_ff][k];
         if (pressed[k]) begin
            phase_in[k] = (ph == PH_OPEN) ? PH_DOWN : PH_HELD;
         end else begin
            phase_in[k] = (ph == PH_HELD) ? PH_UP : PH_OPEN;
         end
      end

      // button 0 sits at lane 0 of row 0 and flips the bank instead of sending
      bank_in = bank_ff ^ (!drive_row_ff && phase_in[0] == PH_UP);
      for (int k = 0; k < BPR; k++) begin
         release_hit[k] = (phase_in[k] == PH_UP) && !(k == 0 && !drive_row_ff);
      end
      cur_vel = vel_bit_ff[bank_in][drive_row_ff];

      msg        = '0;
      msg.mask   = MaxBpr'(release_hit);
      msg.row    = drive_row_ff;
      msg.status = bank_in ? cfg.status_b : cfg.status_a;
      for (int k = 0; k < BPR; k++) begin
         msg.vel[k] = cur_vel[k] ? cfg.vel_high : cfg.vel_low;
      end
      emit = |release_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_row_ff <= 1'b0;
         bank_ff      <= 1'b0;
         for (int r = 0; r < 2; r++) begin
            for (int k = 0; k < BPR; k++) begin
               phase_ff[r][k] <= PH_OPEN;
            end
            vel_bit_ff[0][r] <= '0;
            vel_bit_ff[1][r] <= '0;
         end
      end else if (go) begin
         drive_row_ff <= !drive_row_ff;
         bank_ff      <= bank_in;
         for (int r = 0; r < 2; r++) begin
            if (1'(r) == drive_row_ff) begin
               for (int k = 0; k < BPR; k++) begin
                  phase_ff[r][k] <= phase_in[k];
               end
               vel_bit_ff[bank_in][r] <= vel_bit_ff[bank_in][r] ^ release_hit;
            end
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bmmf_ser.sv]
// ---------------------------------------------------------------------------
// bmmf_ser
// Result buffer: serializes one scan's note messages into MIDI byte beats.
// ---------------------------------------------------------------------------
`default_nettype none

module bmmf_ser #(
   parameter int BPR = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bmmf_pkg::msg_type msg,
   input  wire logic [6:0]        note_base,
   output logic                   buf_free,
   bmmf_rsp_if.source             rsp
);
   import bmmf_pkg::*;

   logic                   busy_ff;
   logic [MaxBpr-1:0]      mask_ff;
   logic                   row_ff;
   logic [7:0]             status_ff;
   logic [MaxBpr-1:0][6:0] vel_ff;
   sel_type                sel_ff;
   logic [3:0]             count_ff;

   logic [2:0]        cur_k;
   logic [MaxBpr-1:0] low_bit;
   logic              single;
   logic [3:0]        button;
   logic [6:0]        note;
   logic              beat;

   always_comb begin
      cur_k = '0;
      for (int i = MaxBpr - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur_k = 3'(i);
         end
      end
      low_bit = mask_ff & (~mask_ff + MaxBpr'(1));
      single  = (mask_ff & (mask_ff - MaxBpr'(1))) == '0;
      button  = row_ff ? (4'(BPR) + {1'b0, cur_k}) : {1'b0, cur_k};
      note    = note_base + 7'(button);

      unique case (sel_ff)
         SEL_STATUS: rsp.midi_byte = status_ff;
         SEL_NOTE:   rsp.midi_byte = {1'b0, note};
         SEL_VEL:    rsp.midi_byte = {1'b0, vel_ff[cur_k]};
         default:    rsp.midi_byte = status_ff;
      endcase

      rsp.valid  = busy_ff;
      rsp.button = button;
      rsp.last   = (sel_ff == SEL_VEL && single) || count_ff == 4'(MaxResults - 1);
      beat       = rsp.valid && rsp.ready;
      buf_free   = !busy_ff || (beat && rsp.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (beat && rsp.last) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mask_ff   <= msg.mask;
         row_ff    <= msg.row;
         status_ff <= msg.status;
         vel_ff    <= msg.vel;
         sel_ff    <= SEL_STATUS;
         count_ff  <= '0;
      end else if (beat) begin
         count_ff <= count_ff + 4'd1;
         unique case (sel_ff)
            SEL_STATUS: sel_ff <= SEL_NOTE;
            SEL_NOTE:   sel_ff <= SEL_VEL;
            default: begin
               sel_ff  <= SEL_STATUS;
               mask_ff <= mask_ff & ~low_bit;
            end
         endcase
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> buf_free)
      else $error("result buffer loaded while still draining");

   a_load_has_msg: assert property (@(posedge clock) disable iff (reset)
      load |-> (msg.mask != '0))
      else $error("empty message set loaded");

   a_busy_mask: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (mask_ff != '0))
      else $error("buffer busy with no pending release");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff < 4'(MaxResults)))
      else $error("byte count past result cap");

   a_more_after_mid: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last) |=> busy_ff)
      else $error("buffer dropped before last beat");

endmodule

`default_nettype wire

[hw/rtl/button_matrix_midi_footswitch.sv]
// ---------------------------------------------------------------------------
// button_matrix_midi_footswitch
// Two-row button matrix scanner sending MIDI note messages on release.
// ---------------------------------------------------------------------------
// Path: an accepted sample is registered, stepped once the result buffer can
//   take its releases, and its MIDI bytes are offered from the buffer registers.
// Throughput: one sample per cycle unless a sample with releases waits for
//   the result buffer; each release sends three bytes (up to 15 bytes).
// Reset: synchronous; buttons open, row 0, bank 0, velocity bits low,
//   registers at their default values.
`default_nettype none

module button_matrix_midi_footswitch #(
   parameter int BPR = 5
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bmmf_req_if.sink                       req_ch,
   bmmf_rsp_if.source                     rsp_ch,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [bmmf_pkg::AddrW-1:0] csr_paddr,
   input  wire logic [bmmf_pkg::DataW-1:0] csr_pwdata,
   output logic      [bmmf_pkg::DataW-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bmmf_pkg::*;

   cfg_type         cfg_ff;
   logic            in_valid_ff;
   logic [PinW-1:0] pins_ff;
   logic            go;
   logic            emit;
   logic            buf_free;
   logic            csr_wr;
   logic [2:0]      reg_idx;
   msg_type         msg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.note_base <= NoteBaseRst;
         cfg_ff.status_a  <= StatusARst;
         cfg_ff.status_b  <= StatusBRst;
         cfg_ff.vel_low   <= VelLowRst;
         cfg_ff.vel_high  <= VelHighRst;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_NOTE_BASE: cfg_ff.note_base <= csr_pwdata[6:0];
            REG_STATUS_A:  cfg_ff.status_a  <= csr_pwdata[7:0];
            REG_STATUS_B:  cfg_ff.status_b  <= csr_pwdata[7:0];
            REG_VEL_LOW:   cfg_ff.vel_low   <= csr_pwdata[6:0];
            REG_VEL_HIGH:  cfg_ff.vel_high  <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NOTE_BASE: csr_prdata = DataW'(cfg_ff.note_base);
         REG_STATUS_A:  csr_prdata = DataW'(cfg_ff.status_a);
         REG_STATUS_B:  csr_prdata = DataW'(cfg_ff.status_b);
         REG_VEL_LOW:   csr_prdata = DataW'(cfg_ff.vel_low);
         REG_VEL_HIGH:  csr_prdata = DataW'(cfg_ff.vel_high);
         default:       csr_prdata = '0;
      endcase
   end

   // a sample with no release steps even while the buffer drains
   assign go           = in_valid_ff && (!emit || buf_free);
   assign req_ch.ready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         pins_ff <= req_ch.pin_status;
      end
   end

   bmmf_scan #(
      .BPR (BPR)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .pins  (pins_ff),
      .cfg   (cfg_ff),
      .emit  (emit),
      .msg   (msg)
   );

   bmmf_ser #(
      .BPR (BPR)
   ) u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (go && emit),
      .msg       (msg),
      .note_base (cfg_ff.note_base),
      .buf_free  (buf_free),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire
